// ===== rtl/pdga_pkg.sv =====
// Shared constants, codes and unit interface types of the Poisson-disk grid acceptor.
// Used by every module of the block; depends on nothing.
package pdga_pkg;

   // grid store and coordinate sizes
   localparam int GRID_CELLS     = 4096;
   localparam int COORD_BITS     = 12;
   localparam int CELL_BITS      = $clog2(GRID_CELLS);
   localparam int INDEX_BITS     = 12;
   localparam int CFG_BITS       = 13;
   localparam int COUNT_BITS     = 7;
   localparam int CSR_INDEX_BITS = 3;

   // derived datapath widths
   localparam int MUL_BITS   = (CFG_BITS > COORD_BITS) ? CFG_BITS : COORD_BITS;
   localparam int PROD_BITS  = 2 * MUL_BITS;
   localparam int KPROD_BITS = COORD_BITS + COUNT_BITS;
   localparam int KSUM_BITS  = ((KPROD_BITS > CELL_BITS) ? KPROD_BITS : CELL_BITS) + 1;
   localparam int NK_BITS    = ((CELL_BITS > COUNT_BITS) ? CELL_BITS : COUNT_BITS) + 2;
   localparam int ENTRY_BITS = 2 * COORD_BITS + 1;
   localparam int DIV_CNT_BITS = $clog2(COORD_BITS);

   // register reset values
   localparam logic [CFG_BITS-1:0]   AREA_WIDTH_RESET   = CFG_BITS'(4096);
   localparam logic [CFG_BITS-1:0]   AREA_HEIGHT_RESET  = CFG_BITS'(4096);
   localparam logic [CFG_BITS-1:0]   CELL_EDGE_RESET    = CFG_BITS'(64);
   localparam logic [CFG_BITS-1:0]   MIN_DIST_RESET     = CFG_BITS'(90);
   localparam logic [COUNT_BITS-1:0] CELLS_ACROSS_RESET = COUNT_BITS'(64);
   localparam logic [COUNT_BITS-1:0] CELLS_DOWN_RESET   = COUNT_BITS'(64);

   // request opcodes
   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_INSERT = 2'd1,
      OP_TEST   = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_AREA_WIDTH   = 3'd0,
      CSR_AREA_HEIGHT  = 3'd1,
      CSR_CELL_EDGE    = 3'd2,
      CSR_MIN_DISTANCE = 3'd3,
      CSR_CELLS_ACROSS = 3'd4,
      CSR_CELLS_DOWN   = 3'd5
   } csr_reg_type;

   // divider command and answer
   typedef struct packed {
      logic                  start;
      logic [COORD_BITS-1:0] dividend;
      logic [CFG_BITS-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [COORD_BITS-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== rtl/pdga_div.sv =====
// Iterative restoring divider, one quotient bit per cycle, for the cell coordinate.
// Depends on pdga_pkg for widths and the command/answer structs.
module pdga_div (
   input  logic                 clock,
   input  logic                 reset,
   input  pdga_pkg::div_req_type div_req,
   output pdga_pkg::div_rsp_type div_rsp
);
   import pdga_pkg::*;

   logic                    busy_ff;
   logic                    done_ff;
   logic [DIV_CNT_BITS-1:0] cnt_ff;
   logic [CFG_BITS-1:0]     rem_ff;
   logic [CFG_BITS-1:0]     dsr_ff;
   logic [COORD_BITS-1:0]   dvd_ff;

   logic [CFG_BITS:0]       trial;
   logic [CFG_BITS:0]       diff;
   logic                    fits;
   logic [CFG_BITS-1:0]     rem_in;

   // one restoring step
   always_comb begin
      trial  = {rem_ff, dvd_ff[COORD_BITS-1]};
      diff   = trial - {1'b0, dsr_ff};
      fits   = trial >= {1'b0, dsr_ff};
      rem_in = fits ? diff[CFG_BITS-1:0] : trial[CFG_BITS-1:0];
   end

   // step control, quotient shifts in behind the dividend
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            dsr_ff  <= div_req.divisor;
            dvd_ff  <= div_req.dividend;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            dvd_ff <= {dvd_ff[COORD_BITS-2:0], fits};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_BITS'(COORD_BITS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = dvd_ff;

endmodule

// ===== rtl/pdga_mul.sv =====
// Shared registered multiplier: cell row offset, squared radius and squared deltas.
// Depends on pdga_pkg for operand and product widths.
module pdga_mul (
   input  logic                           clock,
   input  logic [pdga_pkg::MUL_BITS-1:0]  mul_a,
   input  logic [pdga_pkg::MUL_BITS-1:0]  mul_b,
   output logic [pdga_pkg::PROD_BITS-1:0] mul_p
);
   import pdga_pkg::*;

   logic [PROD_BITS-1:0] prod_ff;

   // product registered before any use
   always_ff @(posedge clock) begin
      prod_ff <= PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
   end

   assign mul_p = prod_ff;

endmodule

// ===== rtl/poisson_disk_grid_acceptor.sv =====
// Poisson-disk acceptance grid: sequencer, grid store and configuration registers.
// Depends on pdga_pkg, pdga_div and pdga_mul.
//
// One request at a time. Insert and test requests first run two divisions by the cell
// edge through one shared divider, then use the shared multiplier for the cell index,
// then, for a test request whose cell lies in the grid and whose point lies in the area,
// scan the clamped 3x3 neighbourhood slot by slot, since every slot goes through the
// single read port of the grid memory and the single multiplier. A clear request sweeps
// the grid memory one cell per cycle; after reset the same sweep runs with req_stall
// high. The result sits in an output register, so a new request is taken while the
// previous result still waits on rsp_stall.
module poisson_disk_grid_acceptor (
   input  logic                                clock,
   input  logic                                reset,
   // configuration
   input  logic                                csr_write,
   input  logic [pdga_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [pdga_pkg::CFG_BITS-1:0]       csr_wdata,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_opcode,
   input  logic [pdga_pkg::COORD_BITS-1:0]     req_point_x,
   input  logic [pdga_pkg::COORD_BITS-1:0]     req_point_y,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_accepted,
   output logic [pdga_pkg::INDEX_BITS-1:0]     rsp_cell_index
);
   import pdga_pkg::*;

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_DIVX, S_DIVY, S_MULK, S_KSUM, S_RSQ,
      S_NADDR, S_NDATA, S_NDY, S_NCMP, S_WRITE, S_CLEAR, S_OUT
   } state_type;

   // configuration registers
   logic [CFG_BITS-1:0]   area_width_ff;
   logic [CFG_BITS-1:0]   area_height_ff;
   logic [CFG_BITS-1:0]   cell_edge_ff;
   logic [CFG_BITS-1:0]   min_dist_ff;
   logic [COUNT_BITS-1:0] cells_across_ff;
   logic [COUNT_BITS-1:0] cells_down_ff;

   // sequencer state and working registers
   state_type             state_ff;
   opcode_type            op_ff;
   logic [COORD_BITS-1:0] px_ff;
   logic [COORD_BITS-1:0] py_ff;
   logic [COORD_BITS-1:0] cx_ff;
   logic [COORD_BITS-1:0] cy_ff;
   logic [CELL_BITS-1:0]  k_ff;
   logic [CELL_BITS-1:0]  clr_ff;
   logic [PROD_BITS-1:0]  r2_ff;
   logic [PROD_BITS-1:0]  dx2_ff;
   logic [1:0]            di_ff;
   logic [1:0]            dj_ff;
   logic                  acc_ff;
   logic [INDEX_BITS-1:0] idx_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_accepted_ff;
   logic [INDEX_BITS-1:0] rsp_cell_index_ff;

   // grid memory: valid bit, x, y
   logic [ENTRY_BITS-1:0] grid_mem [GRID_CELLS];
   logic [ENTRY_BITS-1:0] rd_ff;
   logic                  mem_we;
   logic [CELL_BITS-1:0]  mem_waddr;
   logic [ENTRY_BITS-1:0] mem_wdata;
   logic                  mem_re;
   logic [CELL_BITS-1:0]  mem_raddr;

   // shared units
   div_req_type           div_req;
   div_rsp_type           div_rsp;
   logic [MUL_BITS-1:0]   mul_a;
   logic [MUL_BITS-1:0]   mul_b;
   logic [PROD_BITS-1:0]  mul_p;

   // combinational datapath
   logic                  req_accept;
   logic [CFG_BITS-1:0]   edge_eff;
   logic [KSUM_BITS-1:0]  k_sum;
   logic                  in_grid;
   logic                  area_ok;
   logic                  di_ok;
   logic                  dj_ok;
   logic signed [NK_BITS-1:0] di_off;
   logic signed [NK_BITS-1:0] dj_off;
   logic signed [NK_BITS-1:0] nk;
   logic                  slot_ok;
   logic                  last_slot;
   logic [1:0]            di_next;
   logic [1:0]            dj_next;
   logic                  rd_valid;
   logic [COORD_BITS-1:0] rd_x;
   logic [COORD_BITS-1:0] rd_y;
   logic [COORD_BITS-1:0] dx_abs;
   logic [COORD_BITS-1:0] dy_abs;
   logic [PROD_BITS:0]    dist2;
   logic                  too_close;

   pdga_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   pdga_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         area_width_ff   <= AREA_WIDTH_RESET;
         area_height_ff  <= AREA_HEIGHT_RESET;
         cell_edge_ff    <= CELL_EDGE_RESET;
         min_dist_ff     <= MIN_DIST_RESET;
         cells_across_ff <= CELLS_ACROSS_RESET;
         cells_down_ff   <= CELLS_DOWN_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_AREA_WIDTH:   area_width_ff   <= csr_wdata;
            CSR_AREA_HEIGHT:  area_height_ff  <= csr_wdata;
            CSR_CELL_EDGE:    cell_edge_ff    <= csr_wdata;
            CSR_MIN_DISTANCE: min_dist_ff     <= csr_wdata;
            CSR_CELLS_ACROSS: cells_across_ff <= csr_wdata[COUNT_BITS-1:0];
            CSR_CELLS_DOWN:   cells_down_ff   <= csr_wdata[COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // handshake
   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;

   // divider commands: x at accept, y when x is done
   always_comb begin
      edge_eff         = (cell_edge_ff == '0) ? CFG_BITS'(1) : cell_edge_ff;
      div_req.start    = (state_ff == S_IDLE && req_accept &&
                          (opcode_type'(req_opcode) == OP_INSERT ||
                           opcode_type'(req_opcode) == OP_TEST)) ||
                         (state_ff == S_DIVX && div_rsp.done);
      div_req.dividend = (state_ff == S_IDLE) ? req_point_x : py_ff;
      div_req.divisor  = edge_eff;
   end

   // cell index and range checks
   always_comb begin
      k_sum   = KSUM_BITS'(cx_ff) + KSUM_BITS'(mul_p[KPROD_BITS-1:0]);
      in_grid = (MUL_BITS'(cx_ff) < MUL_BITS'(cells_across_ff)) &&
                (MUL_BITS'(cy_ff) < MUL_BITS'(cells_down_ff)) &&
                (k_sum < KSUM_BITS'(GRID_CELLS));
      area_ok = (MUL_BITS'(px_ff) < MUL_BITS'(area_width_ff)) &&
                (MUL_BITS'(py_ff) < MUL_BITS'(area_height_ff));
   end

   // neighbour slot: clamp, address and slot order
   always_comb begin
      priority if (di_ff == 2'd0) di_ok = (cx_ff != '0);
      else if (di_ff == 2'd2)     di_ok = (MUL_BITS'(cx_ff) + 1'b1) < MUL_BITS'(cells_across_ff);
      else                        di_ok = 1'b1;
      priority if (dj_ff == 2'd0) dj_ok = (cy_ff != '0);
      else if (dj_ff == 2'd2)     dj_ok = (MUL_BITS'(cy_ff) + 1'b1) < MUL_BITS'(cells_down_ff);
      else                        dj_ok = 1'b1;
      priority if (di_ff == 2'd0) di_off = -NK_BITS'(1);
      else if (di_ff == 2'd2)     di_off = NK_BITS'(1);
      else                        di_off = '0;
      priority if (dj_ff == 2'd0) dj_off = -signed'(NK_BITS'(cells_across_ff));
      else if (dj_ff == 2'd2)     dj_off = signed'(NK_BITS'(cells_across_ff));
      else                        dj_off = '0;
      nk        = signed'(NK_BITS'(k_ff)) + di_off + dj_off;
      slot_ok   = di_ok && dj_ok && !nk[NK_BITS-1] &&
                  ($unsigned(nk) < NK_BITS'(GRID_CELLS));
      last_slot = (di_ff == 2'd2) && (dj_ff == 2'd2);
      if (dj_ff == 2'd2) begin
         dj_next = 2'd0;
         di_next = di_ff + 2'd1;
      end else begin
         dj_next = dj_ff + 2'd1;
         di_next = di_ff;
      end
   end

   // distance of the stored point
   always_comb begin
      rd_valid  = rd_ff[ENTRY_BITS-1];
      rd_x      = rd_ff[2*COORD_BITS-1:COORD_BITS];
      rd_y      = rd_ff[COORD_BITS-1:0];
      dx_abs    = (rd_x >= px_ff) ? (rd_x - px_ff) : (px_ff - rd_x);
      dy_abs    = (rd_y >= py_ff) ? (rd_y - py_ff) : (py_ff - rd_y);
      dist2     = (PROD_BITS + 1)'(dx2_ff) + (PROD_BITS + 1)'(mul_p);
      too_close = dist2 < (PROD_BITS + 1)'(r2_ff);
   end

   // multiplier operand select
   always_comb begin
      unique case (state_ff)
         S_MULK: begin
            mul_a = MUL_BITS'(cy_ff);
            mul_b = MUL_BITS'(cells_across_ff);
         end
         S_KSUM: begin
            mul_a = MUL_BITS'(min_dist_ff);
            mul_b = MUL_BITS'(min_dist_ff);
         end
         S_NDATA: begin
            mul_a = MUL_BITS'(dx_abs);
            mul_b = MUL_BITS'(dx_abs);
         end
         S_NDY: begin
            mul_a = MUL_BITS'(dy_abs);
            mul_b = MUL_BITS'(dy_abs);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // grid memory port control
   always_comb begin
      mem_we    = (state_ff == S_INIT) || (state_ff == S_CLEAR) || (state_ff == S_WRITE);
      mem_waddr = (state_ff == S_WRITE) ? k_ff : clr_ff;
      mem_wdata = (state_ff == S_WRITE) ? {1'b1, px_ff, py_ff} : '0;
      mem_re    = (state_ff == S_NADDR) && slot_ok;
      mem_raddr = nk[CELL_BITS-1:0];
   end

   // grid memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= grid_mem[mem_raddr];
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            // clearing pass after reset
            S_INIT: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == CELL_BITS'(GRID_CELLS - 1)) begin
                  clr_ff   <= '0;
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_accept) begin
                  op_ff <= opcode_type'(req_opcode);
                  px_ff <= req_point_x;
                  py_ff <= req_point_y;
                  unique case (opcode_type'(req_opcode))
                     OP_CLEAR: begin
                        clr_ff   <= '0;
                        state_ff <= S_CLEAR;
                     end
                     OP_NONE: begin
                        acc_ff   <= 1'b0;
                        idx_ff   <= '0;
                        state_ff <= S_OUT;
                     end
                     default: state_ff <= S_DIVX;
                  endcase
               end
            end
            S_DIVX: begin
               if (div_rsp.done) begin
                  cx_ff    <= div_rsp.quotient;
                  state_ff <= S_DIVY;
               end
            end
            S_DIVY: begin
               if (div_rsp.done) begin
                  cy_ff    <= div_rsp.quotient;
                  state_ff <= S_MULK;
               end
            end
            S_MULK: state_ff <= S_KSUM;
            // cell index ready, decide what remains
            S_KSUM: begin
               k_ff   <= k_sum[CELL_BITS-1:0];
               idx_ff <= k_sum[INDEX_BITS-1:0];
               acc_ff <= 1'b0;
               priority if (!in_grid)  state_ff <= S_OUT;
               else if (op_ff != OP_TEST) state_ff <= S_WRITE;
               else if (!area_ok)      state_ff <= S_OUT;
               else                    state_ff <= S_RSQ;
            end
            S_RSQ: begin
               r2_ff    <= mul_p;
               di_ff    <= 2'd0;
               dj_ff    <= 2'd0;
               state_ff <= S_NADDR;
            end
            // neighbour scan
            S_NADDR: begin
               if (slot_ok) begin
                  state_ff <= S_NDATA;
               end else if (last_slot) begin
                  state_ff <= S_WRITE;
               end else begin
                  di_ff    <= di_next;
                  dj_ff    <= dj_next;
                  state_ff <= S_NADDR;
               end
            end
            S_NDATA: begin
               if (rd_valid) begin
                  state_ff <= S_NDY;
               end else if (last_slot) begin
                  state_ff <= S_WRITE;
               end else begin
                  di_ff    <= di_next;
                  dj_ff    <= dj_next;
                  state_ff <= S_NADDR;
               end
            end
            S_NDY: begin
               dx2_ff   <= mul_p;
               state_ff <= S_NCMP;
            end
            S_NCMP: begin
               if (too_close) begin
                  state_ff <= S_OUT;
               end else if (last_slot) begin
                  state_ff <= S_WRITE;
               end else begin
                  di_ff    <= di_next;
                  dj_ff    <= dj_next;
                  state_ff <= S_NADDR;
               end
            end
            S_WRITE: begin
               acc_ff   <= 1'b1;
               state_ff <= S_OUT;
            end
            // clear request sweep
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == CELL_BITS'(GRID_CELLS - 1)) begin
                  clr_ff   <= '0;
                  acc_ff   <= 1'b0;
                  idx_ff   <= '0;
                  state_ff <= S_OUT;
               end
            end
            // hand the result to the output register
            S_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff      <= 1'b1;
                  rsp_accepted_ff   <= acc_ff;
                  rsp_cell_index_ff <= idx_ff;
                  state_ff          <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_accepted   = rsp_accepted_ff;
   assign rsp_cell_index = rsp_cell_index_ff;

endmodule

// ===== test/tb_poisson_disk_grid_acceptor.sv =====
// Self-checking testbench for the Poisson-disk grid acceptor: directed corner tests, then
// random rounds of clear, seed and candidate points, with random request gaps and result stalls.
// Depends on pdga_pkg and poisson_disk_grid_acceptor.
`timescale 1ns / 1ps

module tb_poisson_disk_grid_acceptor;
   import pdga_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int TAIL_CYCLES    = 100;
   localparam int COORD_MAX      = (1 << COORD_BITS) - 1;

   typedef struct {
      bit                  accepted;
      bit [INDEX_BITS-1:0] cell_index;
   } grid_answer_type;

   // clock, reset and block inputs
   logic                      clock          = 1'b0;
   logic                      reset          = 1'b1;
   logic                      csr_write      = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index      = '0;
   logic [CFG_BITS-1:0]       csr_wdata      = '0;
   logic                      req_valid      = 1'b0;
   logic                      req_stall;
   logic [1:0]                req_opcode     = '0;
   logic [COORD_BITS-1:0]     req_point_x    = '0;
   logic [COORD_BITS-1:0]     req_point_y    = '0;
   logic                      rsp_valid;
   logic                      rsp_stall      = 1'b0;
   logic                      rsp_accepted;
   logic [INDEX_BITS-1:0]     rsp_cell_index;

   // register mirror
   longint cfg_area_width   = AREA_WIDTH_RESET;
   longint cfg_area_height  = AREA_HEIGHT_RESET;
   longint cfg_cell_edge    = CELL_EDGE_RESET;
   longint cfg_min_distance = MIN_DIST_RESET;
   longint cfg_cells_across = CELLS_ACROSS_RESET;
   longint cfg_cells_down   = CELLS_DOWN_RESET;

   // grid mirror and the points placed since the last clear
   bit           grid_valid [GRID_CELLS];
   int           grid_x [GRID_CELLS];
   int           grid_y [GRID_CELLS];
   int           placed_x [$];
   int           placed_y [$];

   grid_answer_type pending_answers [$];
   int           error_count   = 0;
   int           req_calm_left = 0;

   poisson_disk_grid_acceptor dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_accepted   (rsp_accepted),
      .rsp_cell_index (rsp_cell_index)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // any stored point in the clamped 3x3 block closer than the minimum distance
   function automatic bit neighbour_too_close(longint cx, longint cy, longint px, longint py);
      longint i0, i1, j0, j1, r2, i, j, k, dx, dy;
      i0 = (cx - 1 < 0) ? 0 : cx - 1;
      i1 = (cx + 1 > cfg_cells_across - 1) ? cfg_cells_across - 1 : cx + 1;
      j0 = (cy - 1 < 0) ? 0 : cy - 1;
      j1 = (cy + 1 > cfg_cells_down - 1) ? cfg_cells_down - 1 : cy + 1;
      r2 = cfg_min_distance * cfg_min_distance;
      for (i = i0; i <= i1; i++) begin
         for (j = j0; j <= j1; j++) begin
            k = i + j * cfg_cells_across;
            if (k >= 0 && k < GRID_CELLS && grid_valid[k]) begin
               dx = grid_x[k] - px;
               dy = grid_y[k] - py;
               if (dx * dx + dy * dy < r2) return 1'b1;
            end
         end
      end
      return 1'b0;
   endfunction

   // expected answer for one request, updating the grid mirror
   function automatic grid_answer_type predict_grid_answer(opcode_type op,
                                                           logic [COORD_BITS-1:0] x_in,
                                                           logic [COORD_BITS-1:0] y_in);
      grid_answer_type ans;
      longint       px, py, edge_len, cx, cy, k;
      bit           ok;
      int           i;
      ans.accepted   = 1'b0;
      ans.cell_index = '0;
      px = x_in;
      py = y_in;
      if (op == OP_CLEAR) begin
         for (i = 0; i < GRID_CELLS; i++) grid_valid[i] = 1'b0;
         placed_x.delete();
         placed_y.delete();
         return ans;
      end
      if (op == OP_NONE) return ans;
      // a zero edge acts as one
      edge_len = (cfg_cell_edge == 0) ? 1 : cfg_cell_edge;
      cx = px / edge_len;
      cy = py / edge_len;
      k  = cx + cy * cfg_cells_across;
      ok = (cx < cfg_cells_across) && (cy < cfg_cells_down) && (k < GRID_CELLS);
      ans.cell_index = k[INDEX_BITS-1:0];
      if (op == OP_TEST) begin
         if (px >= cfg_area_width || py >= cfg_area_height) ok = 1'b0;
         else if (ok && neighbour_too_close(cx, cy, px, py)) ok = 1'b0;
      end
      if (ok) begin
         grid_valid[k] = 1'b1;
         grid_x[k]     = int'(px);
         grid_y[k]     = int'(py);
         placed_x.push_back(int'(px));
         placed_y.push_back(int'(py));
         ans.accepted  = 1'b1;
      end
      return ans;
   endfunction

   // request gaps: mostly none or short, a few long, with calm stretches
   function automatic int draw_request_gap();
      int pick;
      if (req_calm_left > 0) begin
         req_calm_left--;
         return 0;
      end
      pick = $urandom_range(99);
      if (pick < 3) req_calm_left = $urandom_range(20, 60);
      if (pick < 55) return 0;
      if (pick < 88) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // coordinate near a placed point, clipped to the field range
   function automatic int nearby_coord(int centre, int spread);
      int v;
      v = centre + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > COORD_MAX) v = COORD_MAX;
      return v;
   endfunction

   // coordinate inside the area, sometimes a little past its edge
   function automatic int area_coord(longint extent);
      longint lim;
      lim = extent + extent / 16;
      if (lim > COORD_MAX) lim = COORD_MAX;
      return $urandom_range(0, int'(lim));
   endfunction

   // send one request and record its expected answer once taken
   task automatic send_request(opcode_type op, int x, int y);
      grid_answer_type ans;
      int           gap;
      gap = draw_request_gap();
      if (gap > 0) begin
         if (req_valid) req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_opcode  <= op;
      req_point_x <= x[COORD_BITS-1:0];
      req_point_y <= y[COORD_BITS-1:0];
      do @(posedge clock); while (req_stall);
      ans = predict_grid_answer(op, x[COORD_BITS-1:0], y[COORD_BITS-1:0]);
      pending_answers.push_back(ans);
   endtask

   // stop sending and wait for every answer
   task automatic wait_idle();
      if (req_valid) req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(csr_reg_type idx, int value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CFG_BITS-1:0];
      @(posedge clock);
      case (idx)
         CSR_AREA_WIDTH:   cfg_area_width   = value & 32'h1FFF;
         CSR_AREA_HEIGHT:  cfg_area_height  = value & 32'h1FFF;
         CSR_CELL_EDGE:    cfg_cell_edge    = value & 32'h1FFF;
         CSR_MIN_DISTANCE: cfg_min_distance = value & 32'h1FFF;
         CSR_CELLS_ACROSS: cfg_cells_across = value & 32'h7F;
         CSR_CELLS_DOWN:   cfg_cells_down   = value & 32'h7F;
         default: ;
      endcase
   endtask

   // write the whole register set; only called with the block idle
   task automatic set_grid(int aw, int ah, int ce, int md, int ca, int cd);
      write_register(CSR_AREA_WIDTH, aw);
      write_register(CSR_AREA_HEIGHT, ah);
      write_register(CSR_CELL_EDGE, ce);
      write_register(CSR_MIN_DISTANCE, md);
      write_register(CSR_CELLS_ACROSS, ca);
      write_register(CSR_CELLS_DOWN, cd);
      csr_write <= 1'b0;
   endtask

   // reset settings: accept, reject by distance, replacement, unused opcode, clear
   task automatic test_basic_requests();
      send_request(OP_TEST, 0, 0);
      send_request(OP_TEST, COORD_MAX, COORD_MAX);
      send_request(OP_TEST, 10, 10);
      send_request(OP_INSERT, 20, 20);
      send_request(OP_TEST, 100, 0);
      send_request(OP_TEST, COORD_MAX, 0);
      send_request(OP_NONE, COORD_MAX, COORD_MAX);
      send_request(OP_CLEAR, COORD_MAX, COORD_MAX);
      send_request(OP_TEST, 10, 10);
      wait_idle();
   endtask

   // points past the area and cells past the grid
   task automatic test_area_and_grid_edges();
      set_grid(1000, 800, 64, 90, 4, 4);
      send_request(OP_TEST, 1000, 5);
      send_request(OP_TEST, 5, 800);
      send_request(OP_INSERT, 999, 799);
      send_request(OP_TEST, 300, 10);
      send_request(OP_TEST, 255, 255);
      wait_idle();
   endtask

   // cell index beyond the store, and neighbours beyond it skipped
   task automatic test_store_bounds();
      set_grid(4096, 4096, 32, 40, 64, 100);
      send_request(OP_INSERT, 0, 2048);
      send_request(OP_INSERT, 5, 2016);
      send_request(OP_TEST, 10, 2047);
      send_request(OP_TEST, 2000, 2040);
      send_request(OP_TEST, COORD_MAX, COORD_MAX);
      wait_idle();
   endtask

   // zero edge, zero distance, zero cell counts
   task automatic test_zero_settings();
      set_grid(4096, 4096, 0, 0, 64, 64);
      send_request(OP_INSERT, 5, 5);
      send_request(OP_TEST, 5, 5);
      send_request(OP_TEST, 63, 0);
      wait_idle();
      set_grid(4096, 4096, 64, 90, 0, 64);
      send_request(OP_TEST, 0, 0);
      send_request(OP_INSERT, 100, 3);
      wait_idle();
      set_grid(4096, 4096, 1, 90, 64, 0);
      send_request(OP_TEST, 1, 1);
      wait_idle();
   endtask

   // an edge and distance of 4096 on a one-point area, then an edge and distance of one
   task automatic test_extreme_settings();
      set_grid(1, 1, 4096, 4096, 1, 1);
      send_request(OP_TEST, 1, 0);
      send_request(OP_INSERT, COORD_MAX, COORD_MAX);
      send_request(OP_TEST, 0, 0);
      send_request(OP_CLEAR, 0, 0);
      send_request(OP_TEST, 0, 0);
      wait_idle();
      set_grid(4096, 4096, 1, 1, 64, 64);
      send_request(OP_TEST, 0, 0);
      send_request(OP_TEST, 1, 0);
      send_request(OP_TEST, 63, 63);
      wait_idle();
   endtask

   // rounds of clear, seed and mostly candidate tests, often near placed points
   task automatic test_random_rounds();
      int         round, n, pick, base, x, y, md, edge_len, aw, ah, ca, cd, spread;
      opcode_type op;
      for (round = 0; round < 5; round++) begin
         if (round == 0) begin
            set_grid(4096, 4096, 64, 90, 64, 64);
         end else begin
            md       = $urandom_range(4, 80);
            edge_len = md * 707 / 1000;
            if (edge_len < 1) edge_len = 1;
            aw = $urandom_range(64, 1024);
            ah = $urandom_range(64, 1024);
            if (aw > edge_len * 64) aw = edge_len * 64;
            if (ah > edge_len * 64) ah = edge_len * 64;
            ca = (aw + edge_len - 1) / edge_len;
            cd = (ah + edge_len - 1) / edge_len;
            // last round lets the grid and the area disagree
            if (round == 4) begin
               ca = $urandom_range(1, 64);
               cd = $urandom_range(1, 64);
            end
            set_grid(aw, ah, edge_len, md, ca, cd);
         end
         send_request(OP_CLEAR, 0, 0);
         send_request(OP_INSERT, area_coord(cfg_area_width), area_coord(cfg_area_height));
         for (n = 0; n < 101; n++) begin
            pick   = $urandom_range(99);
            spread = int'(cfg_min_distance) + 2;
            if (pick < 8) begin
               // noise: any opcode, full-range coordinates, clears kept rare
               if ($urandom_range(19) == 0) op = OP_CLEAR;
               else op = opcode_type'($urandom_range(1, 3));
               send_request(op, $urandom_range(COORD_MAX), $urandom_range(COORD_MAX));
            end else begin
               op = (pick < 14) ? OP_INSERT : OP_TEST;
               if (placed_x.size() > 0 && $urandom_range(1) == 1) begin
                  base = $urandom_range(placed_x.size() - 1);
                  x    = nearby_coord(placed_x[base], spread);
                  y    = nearby_coord(placed_y[base], spread);
               end else begin
                  x = area_coord(cfg_area_width);
                  y = area_coord(cfg_area_height);
               end
               send_request(op, x, y);
            end
         end
         wait_idle();
      end
   endtask

   // result stall: mostly none or short, a few long, with calm stretches
   always @(posedge clock) begin : drive_rsp_stall
      int pick;
      int stall_left;
      int calm_left;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
         calm_left  = 0;
      end else if (calm_left > 0) begin
         calm_left--;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         pick = $urandom_range(99);
         if (pick < 3) calm_left = $urandom_range(30, 120);
         else if (pick < 60) stall_left = 0;
         else if (pick < 90) stall_left = $urandom_range(1, 3);
         else if (pick < 97) stall_left = $urandom_range(4, 12);
         else stall_left = $urandom_range(20, 60);
      end
   end

   // compare each result with the oldest expected answer
   always @(posedge clock) begin : check_results
      grid_answer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            $display("%0t: result with no request pending, expected none, actual %0d/%0d",
                     $time, rsp_accepted, rsp_cell_index);
            error_count++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_accepted !== want.accepted) begin
               $display("%0t: accepted expected %0d actual %0d",
                        $time, want.accepted, rsp_accepted);
               error_count++;
            end
            if (rsp_cell_index !== want.cell_index) begin
               $display("%0t: cell_index expected %0d actual %0d",
                        $time, want.cell_index, rsp_cell_index);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin : watchdog
      int idle_cycles;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles++;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_basic_requests();
      test_area_and_grid_edges();
      test_store_bounds();
      test_zero_settings();
      test_extreme_settings();
      test_random_rounds();
      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      error_count += pending_answers.size();
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/pdga_pkg.sv
rtl/pdga_div.sv
rtl/pdga_mul.sv
rtl/poisson_disk_grid_acceptor.sv
test/tb_poisson_disk_grid_acceptor.sv
